/* rtl/rrp_pkg.sv */
// Shared types, constants and helpers for the request parser.
// Used by the channel interfaces and by every parser module.
package rrp_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 30;
  localparam int unsigned CountW  = 21;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = ValueW;

  // Events per input byte and bundle queue depth
  localparam int unsigned EvMax  = 3;
  localparam int unsigned EvCntW = $clog2(EvMax + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMaxArgCount  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxArgLength = 1'd1;

  // Limits and reset values
  localparam logic [CountW-1:0] CountMask  = {CountW{1'b1}};
  localparam logic [ValueW-1:0] LenMask    = {ValueW{1'b1}};
  localparam logic [CountW-1:0] CountReset = CountW'(1024 * 1024);
  localparam logic [ValueW-1:0] LenReset   = ValueW'(512 * 1024 * 1024);

  // Protocol characters
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  typedef enum logic [KindW-1:0] {
    KIND_ARG_START = 3'd0,
    KIND_ARG_BYTE  = 3'd1,
    KIND_ARG_END   = 3'd2,
    KIND_CMD_END   = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_COUNT   = 9'b000000010,
    PH_DOLLAR  = 9'b000000100,
    PH_LEN     = 9'b000001000,
    PH_DATA    = 9'b000010000,
    PH_DATA_CR = 9'b000100000,
    PH_DATA_LF = 9'b001000000,
    PH_INLINE  = 9'b010000000,
    PH_ERROR   = 9'b100000000
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [ValueW-1:0] value;
  } event_t;

  // All words caused by one input byte
  typedef struct packed {
    logic [EvCntW-1:0]     cnt;
    event_t [EvMax-1:0]    ev;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic event_t mk_ev(kind_e k, logic [ByteW-1:0] b, logic [ValueW-1:0] v);
    event_t e;
    e.kind      = k;
    e.data_byte = b;
    e.value     = v;
    return e;
  endfunction

endpackage

/* rtl/rrp_in_if.sv */
// Input channel: one request byte or a clear command per word.
// Depends on rrp_pkg for field widths.
interface rrp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [rrp_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, output op, output byte_in, input ready);
  modport sink   (input valid, input op, input byte_in, output ready);
endinterface

/* rtl/rrp_out_if.sv */
// Output channel: one parser event per word.
// Depends on rrp_pkg for field widths.
interface rrp_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrp_pkg::KindW-1:0]   kind;
  logic [rrp_pkg::ByteW-1:0]   data_byte;
  logic [rrp_pkg::ValueW-1:0]  value;
  logic                        last;

  modport source (output valid, output kind, output data_byte, output value, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input value, input last,
                  output ready);
endinterface

/* rtl/resp_request_parser.sv */
// Request parser top level: RESP multibulk and inline commands, one byte per word
// in, one event word out. Depends on rrp_pkg, rrp_in_if, rrp_out_if and submodules.
//
// A byte is accepted in any cycle in which the four-entry bundle queue has room,
// and its events (zero to three words) are queued for the output serializer.
// Output words leave one per cycle while the receiver is ready, so the sustained rate
// is one byte per cycle while bytes cause at most one word each (data bytes, number
// digits) and the output does not stall; beyond that the output serializer sets it.
// A clear word (op = 1) produces no output. Limits are to be written by the user
// through the cfg port while the parser is idle (not enforced); no clearing pass.
module resp_request_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rrp_pkg::CfgW-1:0]    cfg_data_i,
  rrp_in_if.sink                      in_i,
  rrp_out_if.source                   out_o
);
  import rrp_pkg::*;

  logic      push, pop;
  bundle_t   push_data, head;
  q_status_t q_status;

  rrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  rrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  rrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

/* rtl/rrp_front.sv */
// Front end: accepts request bytes, runs the protocol state machine and
// builds one event bundle per byte. Depends on rrp_pkg and rrp_in_if.
module rrp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rrp_pkg::CfgW-1:0]    cfg_data_i,
  rrp_in_if.sink                      in_i,
  input  rrp_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output rrp_pkg::bundle_t            bundle_o
);
  import rrp_pkg::*;

  logic [CountW-1:0] max_count_q;
  logic [ValueW-1:0] max_len_q;

  phase_e            phase_q, phase_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              dig_q, dig_d;
  logic              ovf_q, ovf_d;
  logic              cr_q, cr_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] seen_q, seen_d;
  logic [ValueW-1:0] bytes_q, bytes_d;
  logic              tok_q, tok_d;

  logic              accept;
  logic [ByteW-1:0]  c;
  logic              do_inline;
  logic [EvCntW-1:0] n;
  event_t [EvMax-1:0] ev;

  // number line decode
  logic              num_ok, num_err;
  logic [ValueW-1:0] num_acc;
  logic              num_neg, num_dig, num_ovf, num_cr;
  logic [ValueW-1:0] limit;
  logic [ValueW+3:0] prod;
  logic              is_digit;
  logic [ValueW-1:0] bytes_dec;
  logic [CountW-1:0] rem_dec;
  logic [CountW-1:0] seen_inc;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !q_status_i.full;
  assign c        = in_i.byte_in;
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign limit    = (phase_q == PH_COUNT) ? ValueW'(max_count_q) : max_len_q;
  assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                    + (ValueW+4)'(c - ChZero);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= CountReset;
      max_len_q   <= LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxArgCount:  max_count_q <= cfg_data_i[CountW-1:0];
        RegMaxArgLength: max_len_q   <= cfg_data_i[ValueW-1:0];
        default: ;
      endcase
    end
  end

  // strict decimal line: digits, optional leading minus, closing CR LF
  always_comb begin
    num_ok  = 1'b0;
    num_err = 1'b0;
    num_acc = acc_q;
    num_neg = neg_q;
    num_dig = dig_q;
    num_ovf = ovf_q;
    num_cr  = cr_q;
    if (cr_q) begin
      num_cr = 1'b0;
      if (c != ChLf || !dig_q || ovf_q || (neg_q && acc_q != '0) || acc_q > limit) begin
        num_err = 1'b1;
      end else begin
        num_ok = 1'b1;
      end
    end else if (c == ChCr) begin
      num_cr = 1'b1;
    end else if (c == ChMinus && !dig_q && !neg_q) begin
      num_neg = 1'b1;
    end else if (is_digit) begin
      num_dig = 1'b1;
      if (prod > {4'b0, LenMask}) begin
        num_acc = LenMask;
        num_ovf = 1'b1;
      end else begin
        num_acc = prod[ValueW-1:0];
      end
    end else begin
      num_err = 1'b1;
    end
  end

  assign bytes_dec = (bytes_q != '0) ? bytes_q - 1'b1 : bytes_q;
  assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign seen_inc  = (seen_q != CountMask) ? seen_q + 1'b1 : seen_q;

  // protocol state machine and event assembly
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    dig_d     = dig_q;
    ovf_d     = ovf_q;
    cr_d      = cr_q;
    rem_d     = rem_q;
    seen_d    = seen_q;
    bytes_d   = bytes_q;
    tok_d     = tok_q;
    n         = '0;
    ev        = '0;
    do_inline = 1'b0;

    if (in_i.op) begin
      phase_d = PH_IDLE;
      acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
      rem_d = '0; seen_d = '0; bytes_d = '0; tok_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
          rem_d = '0; seen_d = '0; bytes_d = '0; tok_d = 1'b0;
          if (c == ChStar) begin
            phase_d = PH_COUNT;
          end else begin
            phase_d   = PH_INLINE;
            do_inline = 1'b1;
          end
        end
        PH_COUNT: begin
          if (num_err) begin
            phase_d = PH_ERROR;
            ev[n] = mk_ev(KIND_ERROR, '0, '0); n = n + 1'b1;
          end else if (num_ok) begin
            acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
            if (acc_q == '0) begin
              ev[n] = mk_ev(KIND_CMD_END, '0, '0); n = n + 1'b1;
              phase_d = PH_IDLE;
              rem_d = '0; seen_d = '0; bytes_d = '0; tok_d = 1'b0;
            end else begin
              rem_d   = acc_q[CountW-1:0];
              seen_d  = '0;
              phase_d = PH_DOLLAR;
            end
          end else begin
            acc_d = num_acc; neg_d = num_neg; dig_d = num_dig;
            ovf_d = num_ovf; cr_d = num_cr;
          end
        end
        PH_DOLLAR: begin
          if (c == ChDollar) begin
            acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_ERROR;
            ev[n] = mk_ev(KIND_ERROR, '0, '0); n = n + 1'b1;
          end
        end
        PH_LEN: begin
          if (num_err) begin
            phase_d = PH_ERROR;
            ev[n] = mk_ev(KIND_ERROR, '0, '0); n = n + 1'b1;
          end else if (num_ok) begin
            acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
            ev[n] = mk_ev(KIND_ARG_START, '0, acc_q); n = n + 1'b1;
            bytes_d = acc_q;
            phase_d = (acc_q == '0) ? PH_DATA_CR : PH_DATA;
          end else begin
            acc_d = num_acc; neg_d = num_neg; dig_d = num_dig;
            ovf_d = num_ovf; cr_d = num_cr;
          end
        end
        PH_DATA: begin
          ev[n] = mk_ev(KIND_ARG_BYTE, c, '0); n = n + 1'b1;
          bytes_d = bytes_dec;
          if (bytes_dec == '0) phase_d = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (c == ChCr) begin
            phase_d = PH_DATA_LF;
          end else begin
            phase_d = PH_ERROR;
            ev[n] = mk_ev(KIND_ERROR, '0, '0); n = n + 1'b1;
          end
        end
        PH_DATA_LF: begin
          if (c != ChLf) begin
            phase_d = PH_ERROR;
            ev[n] = mk_ev(KIND_ERROR, '0, '0); n = n + 1'b1;
          end else begin
            ev[n] = mk_ev(KIND_ARG_END, '0, '0); n = n + 1'b1;
            seen_d = seen_inc;
            rem_d  = rem_dec;
            if (rem_dec == '0) begin
              ev[n] = mk_ev(KIND_CMD_END, '0, ValueW'(seen_inc)); n = n + 1'b1;
              phase_d = PH_IDLE;
              acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
              rem_d = '0; seen_d = '0; bytes_d = '0; tok_d = 1'b0;
            end else begin
              phase_d = PH_DOLLAR;
            end
          end
        end
        PH_INLINE: do_inline = 1'b1;
        PH_ERROR:  ;
        default:   phase_d = PH_ERROR;
      endcase
    end

    // inline line: space separated tokens, CR right before LF dropped
    if (do_inline) begin
      if (cr_d) begin
        cr_d = 1'b0;
        if (c != ChLf) begin
          if (!tok_d) begin
            tok_d  = 1'b1;
            seen_d = (seen_d != CountMask) ? seen_d + 1'b1 : seen_d;
            ev[n] = mk_ev(KIND_ARG_START, '0, '0); n = n + 1'b1;
          end
          ev[n] = mk_ev(KIND_ARG_BYTE, ChCr, '0); n = n + 1'b1;
        end
      end
      if (c == ChLf) begin
        if (tok_d) begin
          ev[n] = mk_ev(KIND_ARG_END, '0, '0); n = n + 1'b1;
        end
        ev[n] = mk_ev(KIND_CMD_END, '0, ValueW'(seen_d)); n = n + 1'b1;
        phase_d = PH_IDLE;
        acc_d = '0; neg_d = 1'b0; dig_d = 1'b0; ovf_d = 1'b0; cr_d = 1'b0;
        rem_d = '0; seen_d = '0; bytes_d = '0; tok_d = 1'b0;
      end else if (c == ChCr) begin
        cr_d = 1'b1;
      end else if (c == ChSpace) begin
        if (tok_d) begin
          tok_d = 1'b0;
          ev[n] = mk_ev(KIND_ARG_END, '0, '0); n = n + 1'b1;
        end
      end else begin
        if (!tok_d) begin
          tok_d  = 1'b1;
          seen_d = (seen_d != CountMask) ? seen_d + 1'b1 : seen_d;
          ev[n] = mk_ev(KIND_ARG_START, '0, '0); n = n + 1'b1;
        end
        ev[n] = mk_ev(KIND_ARG_BYTE, c, '0); n = n + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cr_q    <= 1'b0;
      rem_q   <= '0;
      seen_q  <= '0;
      bytes_q <= '0;
      tok_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      ovf_q   <= ovf_d;
      cr_q    <= cr_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
      bytes_q <= bytes_d;
      tok_q   <= tok_d;
    end
  end

  assign push_o       = accept && !in_i.op && (n != '0);
  assign bundle_o.cnt = n;
  assign bundle_o.ev  = ev;

  // an error state swallows every request byte
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR && accept && !in_i.op) |-> !push_o)
    else $error("word produced while in error state");

  // a clear always returns the parser to idle
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op) |=> (phase_q == PH_IDLE))
    else $error("clear did not return parser to idle");

endmodule

/* rtl/rrp_queue.sv */
// Short bundle queue between parser front end and output serializer.
// Depends on rrp_pkg for the bundle type and depth.
module rrp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rrp_pkg::bundle_t   push_data_i,
  input  logic               pop_i,
  output rrp_pkg::bundle_t   head_o,
  output rrp_pkg::q_status_t status_o
);
  import rrp_pkg::*;

  bundle_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == QDepth[QPtrW:0]);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // pointers and fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && status_o.full) |-> 1'b0)
    else $error("bundle pushed into full queue");

endmodule

/* rtl/rrp_back.sv */
// Back end: walks the head bundle and presents one event word per cycle while the receiver is ready.
// Depends on rrp_pkg and rrp_out_if.
module rrp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrp_pkg::bundle_t   head_i,
  input  rrp_pkg::q_status_t q_status_i,
  output logic               pop_o,
  rrp_out_if.source          out_o
);
  import rrp_pkg::*;

  logic [EvCntW-1:0] idx_q, idx_d;
  event_t            cur;
  logic              last;
  logic              take;

  assign cur  = head_i.ev[idx_q[EvCntW-1:0]];
  assign last = (idx_q == head_i.cnt - 1'b1);
  assign take = out_o.valid && out_o.ready;

  assign out_o.valid     = !q_status_i.empty;
  assign out_o.kind      = cur.kind;
  assign out_o.data_byte = cur.data_byte;
  assign out_o.value     = cur.value;
  assign out_o.last      = last;
  assign pop_o           = take && last;

  // position inside the head bundle
  always_comb begin
    idx_d = idx_q;
    if (take) idx_d = last ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (idx_q < head_i.cnt))
    else $error("event index beyond bundle count");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(idx_q))
    else $error("event index moved while stalled");

endmodule

/* sim/tb.sv */
// Testbench for resp_request_parser: drives request bytes and clear words, predicts
// every event word and checks each one as it leaves the block.
// Depends on rrp_pkg, rrp_in_if, rrp_out_if and the parser RTL.
module tb;
  import rrp_pkg::*;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseWords   = 12;

  localparam logic OpByte  = 1'b0;
  localparam logic OpClear = 1'b1;

  // One expected event word
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [ValueW-1:0] value;
    logic              last;
  } parse_ev_t;

  // One input word
  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] b;
  } in_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  rrp_in_if  in_if ();
  rrp_out_if out_if ();

  resp_request_parser uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Pacing knobs and bookkeeping
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned useful_words   = 0;
  int unsigned errors         = 0;

  // Predictor copy of the limits and the parse state
  logic [CountW-1:0] lim_count;
  logic [ValueW-1:0] lim_len;
  phase_e            ph;
  logic [ValueW-1:0] num_acc;
  logic              num_neg;
  logic              num_digit;
  logic              num_ovf;
  logic [CountW-1:0] args_left;
  logic [CountW-1:0] args_total;
  logic [ValueW-1:0] bulk_left;
  logic              tok_open;
  logic              cr_wait;

  parse_ev_t step_evs[$];
  parse_ev_t expected_evs[$];
  in_word_t  in_words[$];

  // ---------------------------------------------------------------- predictor

  function automatic void emit(kind_e k, logic [ByteW-1:0] b, logic [ValueW-1:0] v);
    parse_ev_t e;
    e.kind      = k;
    e.data_byte = b;
    e.value     = v;
    e.last      = 1'b0;
    step_evs.push_back(e);
  endfunction

  function automatic void emit_error();
    ph = PH_ERROR;
    emit(KIND_ERROR, '0, '0);
  endfunction

  function automatic void clear_number();
    num_acc   = '0;
    num_neg   = 1'b0;
    num_digit = 1'b0;
    num_ovf   = 1'b0;
    cr_wait   = 1'b0;
  endfunction

  function automatic void clear_parse();
    ph = PH_IDLE;
    clear_number();
    args_left  = '0;
    args_total = '0;
    bulk_left  = '0;
    tok_open   = 1'b0;
  endfunction

  // Strict decimal line: 1 closed with a good number, 0 needs more, -1 protocol error
  function automatic int number_step(logic [ByteW-1:0] c, logic [ValueW-1:0] limit,
                                     output logic [ValueW-1:0] num);
    logic [ValueW+3:0] wide;
    num = '0;
    if (cr_wait) begin
      cr_wait = 1'b0;
      if (c != ChLf || !num_digit || num_ovf) return -1;
      if (num_neg && num_acc != '0) return -1;
      if (num_acc > limit) return -1;
      num = num_acc;
      return 1;
    end
    if (c == ChCr) begin
      cr_wait = 1'b1;
      return 0;
    end
    if (c == ChMinus && !num_digit && !num_neg) begin
      num_neg = 1'b1;
      return 0;
    end
    if (c >= ChZero && c <= ChNine) begin
      wide = (ValueW+4)'(num_acc) * (ValueW+4)'(10) + (ValueW+4)'(c - ChZero);
      if (wide > (ValueW+4)'(LenMask)) begin
        wide    = (ValueW+4)'(LenMask);
        num_ovf = 1'b1;
      end
      num_acc   = wide[ValueW-1:0];
      num_digit = 1'b1;
      return 0;
    end
    return -1;
  endfunction

  // Inline token byte, CR handling already done
  function automatic void inline_plain(logic [ByteW-1:0] c);
    if (c == ChSpace) begin
      if (tok_open) begin
        tok_open = 1'b0;
        emit(KIND_ARG_END, '0, '0);
      end
      return;
    end
    if (!tok_open) begin
      tok_open = 1'b1;
      if (args_total < CountMask) args_total++;
      emit(KIND_ARG_START, '0, '0);
    end
    emit(KIND_ARG_BYTE, c, '0);
  endfunction

  function automatic void inline_step(logic [ByteW-1:0] c);
    // a held CR not followed by LF is token content
    if (cr_wait) begin
      cr_wait = 1'b0;
      if (c != ChLf) inline_plain(ChCr);
    end
    if (c == ChLf) begin
      if (tok_open) emit(KIND_ARG_END, '0, '0);
      emit(KIND_CMD_END, '0, ValueW'(args_total));
      clear_parse();
      return;
    end
    if (c == ChCr) begin
      cr_wait = 1'b1;
      return;
    end
    inline_plain(c);
  endfunction

  // Advance the predicted parser by one accepted word and queue its events
  function automatic void predict_word(logic op, logic [ByteW-1:0] c);
    logic [ValueW-1:0] num;
    int                r;
    parse_ev_t         e;
    step_evs.delete();
    if (op == OpClear) begin
      clear_parse();
      return;
    end
    case (ph)
      PH_IDLE: begin
        clear_parse();
        if (c == ChStar) begin
          ph = PH_COUNT;
        end else begin
          ph = PH_INLINE;
          inline_step(c);
        end
      end
      PH_COUNT: begin
        r = number_step(c, ValueW'(lim_count), num);
        if (r < 0) begin
          emit_error();
        end else if (r > 0) begin
          clear_number();
          if (num == '0) begin
            emit(KIND_CMD_END, '0, '0);
            clear_parse();
          end else begin
            args_left  = num[CountW-1:0];
            args_total = '0;
            ph         = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (c == ChDollar) begin
          clear_number();
          ph = PH_LEN;
        end else begin
          emit_error();
        end
      end
      PH_LEN: begin
        r = number_step(c, lim_len, num);
        if (r < 0) begin
          emit_error();
        end else if (r > 0) begin
          clear_number();
          emit(KIND_ARG_START, '0, num);
          bulk_left = num;
          ph        = (num == '0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        emit(KIND_ARG_BYTE, c, '0);
        if (bulk_left > 0) bulk_left--;
        if (bulk_left == '0) ph = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (c == ChCr) ph = PH_DATA_LF;
        else emit_error();
      end
      PH_DATA_LF: begin
        if (c != ChLf) begin
          emit_error();
        end else begin
          emit(KIND_ARG_END, '0, '0);
          if (args_total < CountMask) args_total++;
          if (args_left > 0) args_left--;
          if (args_left == '0) begin
            emit(KIND_CMD_END, '0, ValueW'(args_total));
            clear_parse();
          end else begin
            ph = PH_DOLLAR;
          end
        end
      end
      PH_INLINE: inline_step(c);
      default: ;
    endcase
    if (step_evs.size() > 0) begin
      e      = step_evs.pop_back();
      e.last = 1'b1;
      step_evs.push_back(e);
    end
    foreach (step_evs[i]) expected_evs.push_back(step_evs[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus building

  function automatic void push_byte(logic [ByteW-1:0] b);
    in_words.push_back(in_word_t'({OpByte, b}));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_crlf();
    push_byte(ChCr);
    push_byte(ChLf);
  endfunction

  function automatic void push_clear();
    in_words.push_back(in_word_t'({OpClear, 8'($urandom)}));
  endfunction

  // Decimal line with the occasional "-0" or leading zero, closed by CR LF
  function automatic void push_number(int unsigned n);
    if (n == 0 && $urandom_range(3) == 0) push_byte(ChMinus);
    else if ($urandom_range(5) == 0) push_byte(ChZero);
    push_text($sformatf("%0d", n));
    push_crlf();
  endfunction

  // Well-formed multibulk command within the current limits
  function automatic void queue_multibulk();
    int unsigned argc;
    int unsigned len;
    int unsigned top;
    argc = $urandom_range(3, 1);
    if (argc > lim_count) argc = lim_count;
    if ($urandom_range(9) == 0) argc = 0;
    push_byte(ChStar);
    push_number(argc);
    for (int a = 0; a < argc; a++) begin
      top = (lim_len < 4) ? lim_len : 4;
      len = $urandom_range(top);
      push_byte(ChDollar);
      push_number(len);
      repeat (len) push_byte(8'($urandom));
      push_crlf();
    end
  endfunction

  // ---------------------------------------------------------------- handshakes

  // Offer one word, wait for it to be taken, then predict its events
  task automatic send_word(logic op, logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid   <= 1'b0;
      in_if.op      <= 1'($urandom);
      in_if.byte_in <= 8'($urandom);
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.byte_in <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (op == OpByte && ph != PH_ERROR) useful_words++;
    predict_word(op, b);
  endtask

  task automatic send_queued();
    in_word_t w;
    while (in_words.size() != 0) begin
      w = in_words.pop_front();
      send_word(w.op, w.b);
    end
  endtask

  // Stop offering and wait for every expected word, plus a short tail
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_evs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both limits, written back to back while the parser is idle
  task automatic set_limits(logic [CfgW-1:0] cnt_lim, logic [CfgW-1:0] len_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegMaxArgCount;
    cfg_data_i <= cnt_lim;
    @(posedge clk_i);
    cfg_idx_i  <= RegMaxArgLength;
    cfg_data_i <= len_lim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    lim_count = cnt_lim[CountW-1:0];
    lim_len   = len_lim;
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- tests

  // Zero count, minus zero, zero length, extreme data bytes
  task automatic test_multibulk();
    push_text("*0");
    push_crlf();
    push_text("*-0");
    push_crlf();
    push_text("*2");
    push_crlf();
    push_text("$0");
    push_crlf();
    push_crlf();
    push_text("$3");
    push_crlf();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(ChCr);
    push_crlf();
    send_queued();
    settle();
  endtask

  // Empty lines, spaces, CR kept as content, clear inside a token
  task automatic test_inline();
    push_crlf();
    push_byte(ChLf);
    push_text("  ab");
    push_byte(ChCr);
    push_byte(ChCr);
    push_text("c ");
    push_byte(ChLf);
    push_text("x");
    push_byte(ChCr);
    push_text(" y");
    push_crlf();
    push_text("zz");
    push_clear();
    send_queued();
    settle();
  endtask

  // Malformed numbers and framing, then limits at and just above reset values
  task automatic test_protocol_errors();
    push_text("*1xz");
    push_clear();
    push_byte(ChStar);
    push_crlf();
    push_clear();
    push_text("*-");
    push_crlf();
    push_clear();
    push_text("*-1");
    push_crlf();
    push_clear();
    push_text("*1");
    push_byte(ChCr);
    push_text("X");
    push_clear();
    push_text("*9999999999");
    push_crlf();
    push_clear();
    push_text("*1");
    push_crlf();
    push_text("X");
    push_clear();
    push_text("*1");
    push_crlf();
    push_text("$1");
    push_crlf();
    push_text("ab");
    push_clear();
    push_text("*1");
    push_crlf();
    push_text("$1");
    push_crlf();
    push_text("a");
    push_byte(ChCr);
    push_text("b");
    push_clear();
    push_text("*1");
    push_crlf();
    push_text("$-2");
    push_crlf();
    push_clear();
    push_text($sformatf("*%0d", CountReset));
    push_crlf();
    push_clear();
    push_text($sformatf("*%0d", CountReset + 1));
    push_crlf();
    push_clear();
    push_text("*1");
    push_crlf();
    push_text($sformatf("$%0d", LenReset));
    push_crlf();
    push_clear();
    push_text("*1");
    push_crlf();
    push_text($sformatf("$%0d", LenReset + 1));
    push_crlf();
    push_clear();
    send_queued();
    settle();
  endtask

  // Mostly well-formed commands with random content, the rest broken or noise
  task automatic test_random_traffic(logic [CfgW-1:0] cnt_lim, logic [CfgW-1:0] len_lim,
                                     int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_words);
    int unsigned      goal;
    int unsigned      pick;
    int unsigned      ntok;
    int unsigned      tlen;
    int unsigned      p;
    logic [ByteW-1:0] c;
    set_limits(cnt_lim, len_lim);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = useful_words + n_words;
    while (useful_words < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_multibulk();
      end else if (pick < 75) begin
        // inline line: tokens of random bytes but space, CR, LF, with an occasional CR inside; no '*' first
        ntok = $urandom_range(3);
        if ($urandom_range(3) == 0) push_byte(ChSpace);
        for (int t = 0; t < ntok; t++) begin
          if (t > 0) repeat ($urandom_range(2, 1)) push_byte(ChSpace);
          tlen = $urandom_range(4, 1);
          for (int i = 0; i < tlen; i++) begin
            do c = 8'($urandom);
            while (c == ChSpace || c == ChCr || c == ChLf ||
                   (in_words.size() == 0 && c == ChStar));
            push_byte(c);
            if ($urandom_range(7) == 0) push_byte(ChCr);
          end
        end
        if ($urandom_range(3) == 0) push_byte(ChSpace);
        if ($urandom_range(1) == 1) push_byte(ChCr);
        push_byte(ChLf);
      end else begin
        case ($urandom_range(4))
          0: begin
            queue_multibulk();
            p = $urandom_range(in_words.size() - 1);
            in_words[p] = in_word_t'({OpByte, 8'($urandom)});
          end
          1: begin
            queue_multibulk();
            p = $urandom_range(in_words.size() - 1);
            while (in_words.size() > p) void'(in_words.pop_back());
          end
          2: repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
          3: begin
            if ($urandom_range(1) == 1) begin
              push_text($sformatf("*%0d", lim_count + 1));
              push_crlf();
            end else begin
              push_text("*1");
              push_crlf();
              push_text($sformatf("$%0d", lim_len + 1));
              push_crlf();
            end
          end
          default: begin
            // empty, lone minus, negative or plain count, with LF or another byte after the CR
            push_byte(ChStar);
            if ($urandom_range(1) == 1) push_byte(ChMinus);
            if ($urandom_range(1) == 1) push_text($sformatf("%0d", $urandom_range(9)));
            push_byte(ChCr);
            push_byte(($urandom_range(1) == 1) ? ChLf : 8'($urandom));
          end
        endcase
        push_clear();
      end
      send_queued();
    end
    settle();
  endtask

  // Receiver holds off while a long bulk argument streams in
  task automatic test_backpressure();
    int unsigned n;
    set_limits(CfgW'(CountReset), LenReset);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n = $urandom_range(32, 20);
    push_text("*1");
    push_crlf();
    push_text($sformatf("$%0d", n));
    push_crlf();
    repeat (n) push_byte(8'($urandom));
    push_crlf();
    hold_req <= 1'b1;
    send_queued();
    settle();
    hold_req <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output ready: random stalls, plus one long counted hold on request
  initial begin
    int unsigned held;
    held         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && held < HoldCycles) begin
        out_if.ready <= 1'b0;
        held++;
      end else begin
        if (!hold_req) held = 0;
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    parse_ev_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_evs.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d byte %h value %0d last %b",
                                  out_if.kind, out_if.data_byte, out_if.value, out_if.last));
      end else begin
        want = expected_evs.pop_front();
        if (out_if.kind !== want.kind || out_if.data_byte !== want.data_byte ||
            out_if.value !== want.value || out_if.last !== want.last) begin
          report_mismatch($sformatf(
            "got kind %0d byte %h value %0d last %b, want kind %0d byte %h value %0d last %b",
            out_if.kind, out_if.data_byte, out_if.value, out_if.last,
            want.kind, want.data_byte, want.value, want.last));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegMaxArgCount;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.op      = OpByte;
    in_if.byte_in = '0;
    lim_count     = CountReset;
    lim_len       = LenReset;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_multibulk();
    test_inline();
    test_protocol_errors();
    test_random_traffic(CfgW'(CountReset), LenReset, 0, 0, PhaseWords);
    test_random_traffic(CfgW'(2), CfgW'(3), 71, 0, PhaseWords);
    test_random_traffic(CfgW'(CountReset), CfgW'(0), 0, 71, PhaseWords);
    test_random_traffic(CfgW'(0), LenReset, 6, 6, PhaseWords);
    test_backpressure();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rrp_pkg.sv
rtl/rrp_in_if.sv
rtl/rrp_out_if.sv
rtl/rrp_front.sv
rtl/rrp_queue.sv
rtl/rrp_back.sv
rtl/resp_request_parser.sv
sim/tb.sv
